// ===== rtl/core/rcb_pkg.sv =====
// ----------------------------------------------------------------------------
// rcb_pkg
// Shared types, constants and saturating helpers for the ray caster.
// ----------------------------------------------------------------------------
package rcb_pkg;

    localparam int VALUE_BITS        = 32;
    localparam int BEAM_BITS         = 18;
    localparam int DIST_BITS         = 31;
    localparam int COUNT_BITS        = 7;
    localparam int INDEX_BITS        = 6;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int MAX_OBSTACLES_DEF = 64;

    localparam logic [DIST_BITS-1:0] MAX_RANGE_RST = 31'd655360;

    // internal Q32.16 values saturate to +-(2^48 - 1)
    localparam int QB = 48;
    localparam int FB = 16;
    typedef logic signed [QB:0]   q_t;
    typedef logic signed [QB+1:0] qs_t;

    localparam q_t Q_MAX = {1'b0, {QB{1'b1}}};
    localparam q_t Q_MIN = -Q_MAX;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CAST    = 1'b1;
    localparam logic SHAPE_CIRCLE = 1'b0;
    localparam logic SHAPE_BOX    = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RANGE      = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OBSTACLE_COUNT = 1'b1;

    typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_SQRT} alu_op_t;

    typedef enum logic [1:0] {AL_IDLE, AL_RUN, AL_DONE} alu_state_t;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_DIR0, SQ_DIR1, SQ_DIR2, SQ_DIR3, SQ_READ, SQ_ROW,
        SQ_C0, SQ_C1, SQ_C2, SQ_C3, SQ_C4, SQ_C5, SQ_C6, SQ_C7,
        SQ_B0, SQ_B1, SQ_B2, SQ_B3, SQ_B4, SQ_OUT
    } seq_state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        q_t      a;
        q_t      b;
    } alu_req_t;

    typedef struct packed {
        logic done;
        q_t   result;
    } alu_rsp_t;

    typedef struct packed {
        logic                         shape;
        logic signed [VALUE_BITS-1:0] p0;
        logic signed [VALUE_BITS-1:0] p1;
        logic signed [VALUE_BITS-1:0] p2;
        logic signed [VALUE_BITS-1:0] p3;
    } row_t;

    function automatic q_t q_sat(input qs_t v);
        if (v > qs_t'(Q_MAX))
            return Q_MAX;
        else if (v < qs_t'(Q_MIN))
            return Q_MIN;
        else
            return v[QB:0];
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        return q_sat(qs_t'(a) + qs_t'(b));
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        return q_sat(qs_t'(a) - qs_t'(b));
    endfunction

endpackage

// ===== rtl/core/rcb_alu.sv =====
// ----------------------------------------------------------------------------
// rcb_alu
// Shared multi-cycle unit: saturating Q32.16 multiply (radix 16),
// Q32.16 divide (restoring, one bit a cycle) and integer square root.
// ----------------------------------------------------------------------------
module rcb_alu
(
    input  logic              clk,
    input  logic              rst_n,
    input  rcb_pkg::alu_req_t req,
    output rcb_pkg::alu_rsp_t rsp
);

    localparam int QB  = rcb_pkg::QB;
    localparam int FB  = rcb_pkg::FB;
    localparam int WW  = 2 * QB;
    localparam int DW  = QB + FB;
    localparam int RW  = QB + 1;
    localparam int MUL_STEPS  = QB / 4;
    localparam int DIV_STEPS  = DW;
    localparam int SQRT_STEPS = DW / 2;

    rcb_pkg::alu_state_t state_reg, state_next;
    rcb_pkg::alu_op_t    op_reg, op_next;
    logic                neg_reg, neg_next;
    logic [QB-1:0]       ma_reg, ma_next;
    logic [QB-1:0]       mb_reg, mb_next;
    logic [WW-1:0]       work_reg, work_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [6:0]          cnt_reg, cnt_next;

    rcb_pkg::q_t a_mag, b_mag;
    logic [6:0]  last_cnt;
    logic [QB+3:0] mul_sum;
    logic [RW-1:0] div_shift;
    logic [RW-1:0] sq_shift;
    logic [RW-1:0] sq_trial;
    logic [QB-1:0] res_mag;
    rcb_pkg::q_t   res_pos;

    assign a_mag = (req.a < 0) ? -req.a : req.a;
    assign b_mag = (req.b < 0) ? -req.b : req.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcb_pkg::AL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    always_comb
    begin
        unique case (op_reg)
            rcb_pkg::ALU_MUL:  last_cnt = 7'(MUL_STEPS - 1);
            rcb_pkg::ALU_DIV:  last_cnt = 7'(DIV_STEPS - 1);
            default:           last_cnt = 7'(SQRT_STEPS - 1);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mul_sum    = (QB+4)'(work_reg[WW-1:QB]) + (QB+4)'(ma_reg) * (QB+4)'(work_reg[3:0]);
        div_shift  = {rem_reg[RW-2:0], work_reg[DW-1]};
        sq_shift   = {rem_reg[RW-3:0], work_reg[DW-1:DW-2]};
        sq_trial   = RW'({work_reg[WW-1:DW], 2'b01});

        unique case (state_reg)
            rcb_pkg::AL_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    neg_next = (req.op != rcb_pkg::ALU_SQRT) && ((req.a < 0) != (req.b < 0));
                    ma_next  = a_mag[QB-1:0];
                    mb_next  = b_mag[QB-1:0];
                    rem_next = '0;
                    cnt_next = '0;
                    if (req.op == rcb_pkg::ALU_MUL)
                        work_next = {{QB{1'b0}}, b_mag[QB-1:0]};
                    else
                        work_next = {{(WW-DW){1'b0}}, a_mag[QB-1:0], {FB{1'b0}}};
                    state_next = rcb_pkg::AL_RUN;
                end
            end
            rcb_pkg::AL_RUN:
            begin
                unique case (op_reg)
                    rcb_pkg::ALU_MUL:
                    begin
                        work_next = {mul_sum, work_reg[QB-1:4]};
                    end
                    rcb_pkg::ALU_DIV:
                    begin
                        if (div_shift >= {1'b0, mb_reg})
                        begin
                            rem_next  = div_shift - {1'b0, mb_reg};
                            work_next = {work_reg[WW-1:DW], work_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next  = div_shift;
                            work_next = {work_reg[WW-1:DW], work_reg[DW-2:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        // root lives in the top bits, radicand shifts out two bits a step
                        if (sq_shift >= sq_trial)
                        begin
                            rem_next  = sq_shift - sq_trial;
                            work_next = {work_reg[WW-2:DW], 1'b1, work_reg[DW-3:0], 2'b00};
                        end
                        else
                        begin
                            rem_next  = sq_shift;
                            work_next = {work_reg[WW-2:DW], 1'b0, work_reg[DW-3:0], 2'b00};
                        end
                    end
                endcase
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == last_cnt)
                    state_next = rcb_pkg::AL_DONE;
            end
            default:
            begin
                state_next = rcb_pkg::AL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            rcb_pkg::ALU_MUL:
                res_mag = (|work_reg[WW-1:DW]) ? {QB{1'b1}} : work_reg[DW-1:FB];
            rcb_pkg::ALU_DIV:
                res_mag = (|work_reg[DW-1:QB]) ? {QB{1'b1}} : work_reg[QB-1:0];
            default:
                res_mag = QB'(work_reg[WW-1:DW]);
        endcase
        res_pos = {1'b0, res_mag};
    end

    assign rsp.done   = (state_reg == rcb_pkg::AL_DONE);
    assign rsp.result = neg_reg ? -res_pos : res_pos;

endmodule

// ===== rtl/core/rcb_table.sv =====
// ----------------------------------------------------------------------------
// rcb_table
// Obstacle table: one row per slot holding shape and four parameters.
// ----------------------------------------------------------------------------
module rcb_table
#(
    parameter int MAX_OBSTACLES = rcb_pkg::MAX_OBSTACLES_DEF,
    parameter int AW            = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  rcb_pkg::row_t     wr_row,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output rcb_pkg::row_t     rd_row
);

    rcb_pkg::row_t mem [MAX_OBSTACLES];
    rcb_pkg::row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_row_reg <= mem[rd_addr];
    end

    assign rd_row = rd_row_reg;

endmodule

// ===== rtl/core/rcb_seq.sv =====
// ----------------------------------------------------------------------------
// rcb_seq
// Cast sequencer: rotates the beam, walks the obstacle table and runs the
// circle and slab tests through the shared arithmetic unit.
// ----------------------------------------------------------------------------
module rcb_seq
#(
    parameter int MAX_OBSTACLES = rcb_pkg::MAX_OBSTACLES_DEF,
    parameter int AW            = 6,
    parameter int CW            = 7
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  rcb_pkg::q_t                    ox_in,
    input  rcb_pkg::q_t                    oy_in,
    input  rcb_pkg::q_t                    hc_in,
    input  rcb_pkg::q_t                    hs_in,
    input  rcb_pkg::q_t                    bc_in,
    input  rcb_pkg::q_t                    bs_in,
    input  logic [rcb_pkg::DIST_BITS-1:0]  max_range,
    input  logic [CW-1:0]                  obst_n,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    input  rcb_pkg::row_t                  rd_row,
    output rcb_pkg::alu_req_t              alu_req,
    input  rcb_pkg::alu_rsp_t              alu_rsp,
    input  logic                           out_free,
    output logic                           finish,
    output logic [rcb_pkg::DIST_BITS-1:0]  best,
    output logic                           busy
);

    localparam int QB = rcb_pkg::QB;
    localparam int DB = rcb_pkg::DIST_BITS;

    rcb_pkg::seq_state_t state_reg, state_next;
    logic                issued_reg, issued_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [DB-1:0]       best_reg, best_next;
    rcb_pkg::row_t       row_reg, row_next;

    rcb_pkg::q_t ox_reg, ox_next, oy_reg, oy_next;
    rcb_pkg::q_t hc_reg, hc_next, hs_reg, hs_next;
    rcb_pkg::q_t bc_reg, bc_next, bs_reg, bs_next;
    rcb_pkg::q_t dx_reg, dx_next, dy_reg, dy_next;
    rcb_pkg::q_t ocx_reg, ocx_next, ocy_reg, ocy_next;
    rcb_pkg::q_t ta_reg, ta_next, bv_reg, bv_next, cv_reg, cv_next;
    rcb_pkg::q_t lo_reg, lo_next, hi_reg, hi_next;

    rcb_pkg::q_t p0, p1, p2, p3;
    rcb_pkg::q_t best_q;

    assign p0     = rcb_pkg::q_t'(row_reg.p0);
    assign p1     = rcb_pkg::q_t'(row_reg.p1);
    assign p2     = rcb_pkg::q_t'(row_reg.p2);
    assign p3     = rcb_pkg::q_t'(row_reg.p3);
    assign best_q = rcb_pkg::q_t'({{(QB+1-DB){1'b0}}, best_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcb_pkg::SQ_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        best_reg <= best_next;
        row_reg  <= row_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        hc_reg   <= hc_next;
        hs_reg   <= hs_next;
        bc_reg   <= bc_next;
        bs_reg   <= bs_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ocx_reg  <= ocx_next;
        ocy_reg  <= ocy_next;
        ta_reg   <= ta_next;
        bv_reg   <= bv_next;
        cv_reg   <= cv_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
    end

    always_comb
    begin
        rcb_pkg::q_t r;
        rcb_pkg::q_t nb;
        rcb_pkg::q_t t1;
        rcb_pkg::q_t t2;
        rcb_pkg::q_t th;
        rcb_pkg::q_t nearv;
        rcb_pkg::q_t farv;
        logic        got;
        logic        use_alu;
        logic        hit;

        r       = alu_rsp.result;
        got     = issued_reg && alu_rsp.done;
        use_alu = 1'b0;
        hit     = 1'b0;
        th      = '0;
        nb      = -bv_reg;
        t1      = rcb_pkg::q_sub(nb, r);
        t2      = rcb_pkg::q_add(nb, r);
        nearv   = (ta_reg < r) ? ta_reg : r;
        farv    = (ta_reg < r) ? r : ta_reg;

        state_next = state_reg;
        j_next     = j_reg;
        best_next  = best_reg;
        row_next   = row_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        hc_next    = hc_reg;
        hs_next    = hs_reg;
        bc_next    = bc_reg;
        bs_next    = bs_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        ocx_next   = ocx_reg;
        ocy_next   = ocy_reg;
        ta_next    = ta_reg;
        bv_next    = bv_reg;
        cv_next    = cv_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;

        rd_en        = 1'b0;
        rd_addr      = j_reg[AW-1:0];
        alu_req.op   = rcb_pkg::ALU_MUL;
        alu_req.a    = ta_reg;
        alu_req.b    = ta_reg;
        finish       = 1'b0;

        unique case (state_reg)
            rcb_pkg::SQ_IDLE:
            begin
                if (start)
                begin
                    ox_next    = ox_in;
                    oy_next    = oy_in;
                    hc_next    = hc_in;
                    hs_next    = hs_in;
                    bc_next    = bc_in;
                    bs_next    = bs_in;
                    state_next = rcb_pkg::SQ_DIR0;
                end
            end
            rcb_pkg::SQ_DIR0:
            begin
                use_alu   = 1'b1;
                alu_req.a = bc_reg;
                alu_req.b = hc_reg;
                if (got)
                begin
                    ta_next    = r;
                    state_next = rcb_pkg::SQ_DIR1;
                end
            end
            rcb_pkg::SQ_DIR1:
            begin
                use_alu   = 1'b1;
                alu_req.a = bs_reg;
                alu_req.b = hs_reg;
                if (got)
                begin
                    dx_next    = rcb_pkg::q_sub(ta_reg, r);
                    state_next = rcb_pkg::SQ_DIR2;
                end
            end
            rcb_pkg::SQ_DIR2:
            begin
                use_alu   = 1'b1;
                alu_req.a = bc_reg;
                alu_req.b = hs_reg;
                if (got)
                begin
                    ta_next    = r;
                    state_next = rcb_pkg::SQ_DIR3;
                end
            end
            rcb_pkg::SQ_DIR3:
            begin
                use_alu   = 1'b1;
                alu_req.a = bs_reg;
                alu_req.b = hc_reg;
                if (got)
                begin
                    dy_next    = rcb_pkg::q_add(ta_reg, r);
                    best_next  = max_range;
                    j_next     = '0;
                    state_next = rcb_pkg::SQ_READ;
                end
            end
            rcb_pkg::SQ_READ:
            begin
                if (j_reg == obst_n)
                begin
                    state_next = rcb_pkg::SQ_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = rcb_pkg::SQ_ROW;
                end
            end
            rcb_pkg::SQ_ROW:
            begin
                row_next = rd_row;
                lo_next  = rcb_pkg::Q_MIN;
                hi_next  = rcb_pkg::Q_MAX;
                if (rd_row.shape == rcb_pkg::SHAPE_BOX)
                    state_next = rcb_pkg::SQ_B0;
                else
                    state_next = rcb_pkg::SQ_C0;
            end
            rcb_pkg::SQ_C0:
            begin
                ocx_next   = rcb_pkg::q_sub(ox_reg, p0);
                ocy_next   = rcb_pkg::q_sub(oy_reg, p1);
                state_next = rcb_pkg::SQ_C1;
            end
            rcb_pkg::SQ_C1:
            begin
                use_alu   = 1'b1;
                alu_req.a = ocx_reg;
                alu_req.b = dx_reg;
                if (got)
                begin
                    ta_next    = r;
                    state_next = rcb_pkg::SQ_C2;
                end
            end
            rcb_pkg::SQ_C2:
            begin
                use_alu   = 1'b1;
                alu_req.a = ocy_reg;
                alu_req.b = dy_reg;
                if (got)
                begin
                    bv_next    = rcb_pkg::q_add(ta_reg, r);
                    state_next = rcb_pkg::SQ_C3;
                end
            end
            rcb_pkg::SQ_C3:
            begin
                use_alu   = 1'b1;
                alu_req.a = ocx_reg;
                alu_req.b = ocx_reg;
                if (got)
                begin
                    ta_next    = r;
                    state_next = rcb_pkg::SQ_C4;
                end
            end
            rcb_pkg::SQ_C4:
            begin
                use_alu   = 1'b1;
                alu_req.a = ocy_reg;
                alu_req.b = ocy_reg;
                if (got)
                begin
                    ta_next    = rcb_pkg::q_add(ta_reg, r);
                    state_next = rcb_pkg::SQ_C5;
                end
            end
            rcb_pkg::SQ_C5:
            begin
                use_alu   = 1'b1;
                alu_req.a = p2;
                alu_req.b = p2;
                if (got)
                begin
                    cv_next    = rcb_pkg::q_sub(ta_reg, r);
                    state_next = rcb_pkg::SQ_C6;
                end
            end
            rcb_pkg::SQ_C6:
            begin
                use_alu   = 1'b1;
                alu_req.a = bv_reg;
                alu_req.b = bv_reg;
                if (got)
                begin
                    ta_next = rcb_pkg::q_sub(r, cv_reg);
                    if (rcb_pkg::q_sub(r, cv_reg) < 0)
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = rcb_pkg::SQ_READ;
                    end
                    else
                    begin
                        state_next = rcb_pkg::SQ_C7;
                    end
                end
            end
            rcb_pkg::SQ_C7:
            begin
                // ta holds the discriminant; sqrt of disc << 16
                use_alu    = 1'b1;
                alu_req.op = rcb_pkg::ALU_SQRT;
                alu_req.a  = ta_reg;
                alu_req.b  = ta_reg;
                if (got)
                begin
                    if (t1 >= 0)
                    begin
                        hit = 1'b1;
                        th  = t1;
                    end
                    else if (t2 >= 0)
                    begin
                        hit = 1'b1;
                        th  = t2;
                    end
                    if (hit && (th < best_q))
                        best_next = th[DB-1:0];
                    j_next     = j_reg + 1'b1;
                    state_next = rcb_pkg::SQ_READ;
                end
            end
            rcb_pkg::SQ_B0:
            begin
                if (dx_reg == 0)
                begin
                    if ((ox_reg < p0) || (ox_reg > p2))
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = rcb_pkg::SQ_READ;
                    end
                    else
                    begin
                        state_next = rcb_pkg::SQ_B2;
                    end
                end
                else
                begin
                    use_alu    = 1'b1;
                    alu_req.op = rcb_pkg::ALU_DIV;
                    alu_req.a  = rcb_pkg::q_sub(p0, ox_reg);
                    alu_req.b  = dx_reg;
                    if (got)
                    begin
                        ta_next    = r;
                        state_next = rcb_pkg::SQ_B1;
                    end
                end
            end
            rcb_pkg::SQ_B1:
            begin
                use_alu    = 1'b1;
                alu_req.op = rcb_pkg::ALU_DIV;
                alu_req.a  = rcb_pkg::q_sub(p2, ox_reg);
                alu_req.b  = dx_reg;
                if (got)
                begin
                    if (nearv > lo_reg)
                        lo_next = nearv;
                    if (farv < hi_reg)
                        hi_next = farv;
                    state_next = rcb_pkg::SQ_B2;
                end
            end
            rcb_pkg::SQ_B2:
            begin
                if (dy_reg == 0)
                begin
                    if ((oy_reg < p1) || (oy_reg > p3))
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = rcb_pkg::SQ_READ;
                    end
                    else
                    begin
                        state_next = rcb_pkg::SQ_B4;
                    end
                end
                else
                begin
                    use_alu    = 1'b1;
                    alu_req.op = rcb_pkg::ALU_DIV;
                    alu_req.a  = rcb_pkg::q_sub(p1, oy_reg);
                    alu_req.b  = dy_reg;
                    if (got)
                    begin
                        ta_next    = r;
                        state_next = rcb_pkg::SQ_B3;
                    end
                end
            end
            rcb_pkg::SQ_B3:
            begin
                use_alu    = 1'b1;
                alu_req.op = rcb_pkg::ALU_DIV;
                alu_req.a  = rcb_pkg::q_sub(p3, oy_reg);
                alu_req.b  = dy_reg;
                if (got)
                begin
                    if (nearv > lo_reg)
                        lo_next = nearv;
                    if (farv < hi_reg)
                        hi_next = farv;
                    state_next = rcb_pkg::SQ_B4;
                end
            end
            rcb_pkg::SQ_B4:
            begin
                if ((lo_reg <= hi_reg) && (hi_reg >= 0))
                begin
                    th = (lo_reg > 0) ? lo_reg : '0;
                    if (th < best_q)
                        best_next = th[DB-1:0];
                end
                j_next     = j_reg + 1'b1;
                state_next = rcb_pkg::SQ_READ;
            end
            rcb_pkg::SQ_OUT:
            begin
                finish = 1'b1;
                if (out_free)
                    state_next = rcb_pkg::SQ_IDLE;
            end
            default:
            begin
                state_next = rcb_pkg::SQ_IDLE;
            end
        endcase

        alu_req.start = use_alu && !issued_reg;
        if (!use_alu)
            issued_next = 1'b0;
        else if (issued_reg)
            issued_next = !alu_rsp.done;
        else
            issued_next = 1'b1;
    end

    assign best = best_reg;
    assign busy = (state_reg != rcb_pkg::SQ_IDLE);

endmodule

// ===== rtl/core/ray_circle_box_nearest_hit_top.sv =====
// ----------------------------------------------------------------------------
// ray_circle_box_nearest_hit_top
// Nearest-hit ray caster over a table of circles and axis-aligned boxes.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall) carries either a load request
// (func = 0), which writes one obstacle row into the table in the cycle it
// is taken, or a cast request (func = 1), which returns one distance on the
// response channel (rsp_valid / rsp_stall). Loads produce no response.
// A cast runs on one shared multi-cycle unit (multiply 12 steps, divide 64,
// square root 32), which it uses as follows:
//   beam rotation        4 multiplies
//   per circle slot      6 multiplies and 1 square root (no root on a miss)
//   per box slot         up to 4 divides
// req_stall is high for the whole cast. The result goes to an output
// register, so a new request is taken as soon as the cast has handed its
// result over, even while rsp_stall holds that result. If the output
// register is still full when a cast ends, the cast waits for it.
// Reset clears control state; max_range resets to 10.0, obstacle_count to 0.
// Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module ray_circle_box_nearest_hit_top
#(
    parameter int MAX_OBSTACLES = rcb_pkg::MAX_OBSTACLES_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      req_valid,
    output logic                                      req_stall,
    input  logic                                      func,
    input  logic [rcb_pkg::INDEX_BITS-1:0]            entry_index,
    input  logic                                      shape_kind,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0]     value_0,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0]     value_1,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0]     value_2,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0]     value_3,
    input  logic signed [rcb_pkg::BEAM_BITS-1:0]      value_4,
    input  logic signed [rcb_pkg::BEAM_BITS-1:0]      value_5,
    output logic                                      rsp_valid,
    input  logic                                      rsp_stall,
    output logic [rcb_pkg::DIST_BITS-1:0]             distance,
    input  logic                                      cfg_we,
    input  logic [rcb_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [rcb_pkg::DIST_BITS-1:0]             cfg_data
);

    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW = $clog2(MAX_OBSTACLES + 1);

    logic [rcb_pkg::DIST_BITS-1:0]  max_range_reg, max_range_next;
    logic [rcb_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [rcb_pkg::DIST_BITS-1:0]  distance_reg, distance_next;

    logic                           req_take;
    logic                           busy;
    logic                           finish;
    logic                           out_free;
    logic [rcb_pkg::DIST_BITS-1:0]  best;
    logic [CW-1:0]                  obst_n;
    logic                           wr_en;
    rcb_pkg::row_t                  wr_row;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    rcb_pkg::row_t                  rd_row;
    rcb_pkg::alu_req_t              alu_req;
    rcb_pkg::alu_rsp_t              alu_rsp;

    assign req_stall = busy;
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign obst_n = (32'(count_reg) > MAX_OBSTACLES) ? CW'(MAX_OBSTACLES) : CW'(count_reg);

    assign wr_en = req_take && (func == rcb_pkg::FUNC_LOAD)
                   && (32'(entry_index) < MAX_OBSTACLES);
    assign wr_row.shape = shape_kind;
    assign wr_row.p0    = value_0;
    assign wr_row.p1    = value_1;
    assign wr_row.p2    = value_2;
    assign wr_row.p3    = value_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= rcb_pkg::MAX_RANGE_RST;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            max_range_reg <= max_range_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
    end

    always_comb
    begin
        max_range_next = max_range_reg;
        count_next     = count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rcb_pkg::CFG_MAX_RANGE:      max_range_next = cfg_data;
                rcb_pkg::CFG_OBSTACLE_COUNT: count_next = cfg_data[rcb_pkg::COUNT_BITS-1:0];
                default:                     max_range_next = max_range_reg;
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        distance_next  = distance_reg;
        if (finish && out_free)
        begin
            rsp_valid_next = 1'b1;
            distance_next  = best;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign distance  = distance_reg;

    rcb_table
    #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .AW            (AW)
    )
    u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_row  (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    rcb_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    rcb_seq
    #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .AW            (AW),
        .CW            (CW)
    )
    u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_take && (func == rcb_pkg::FUNC_CAST)),
        .ox_in     (rcb_pkg::q_t'(value_0)),
        .oy_in     (rcb_pkg::q_t'(value_1)),
        .hc_in     (rcb_pkg::q_t'(value_2)),
        .hs_in     (rcb_pkg::q_t'(value_3)),
        .bc_in     (rcb_pkg::q_t'(value_4)),
        .bs_in     (rcb_pkg::q_t'(value_5)),
        .max_range (max_range_reg),
        .obst_n    (obst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_row    (rd_row),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .out_free  (out_free),
        .finish    (finish),
        .best      (best),
        .busy      (busy)
    );

    // a cast request locks out further requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && (func == rcb_pkg::FUNC_CAST)) |=> req_stall)
        else $error("cast request did not raise req_stall");

    // a response only appears at the end of a cast
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(busy))
        else $error("response without a cast in flight");

    // the nearest hit never exceeds the configured range
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (best <= max_range_reg))
        else $error("distance above max_range");

    // load requests never start the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && (func == rcb_pkg::FUNC_LOAD)) |=> !req_stall)
        else $error("load request stalled the channel");

endmodule

// ===== tb/ray_hit_checker.sv =====
// ----------------------------------------------------------------------------
// ray_hit_checker
// Watches the request, response and config ports of the ray caster. It keeps
// its own obstacle table and register copies, predicts the nearest-hit
// distance of every cast, and compares each response with the oldest one.
// ----------------------------------------------------------------------------
module ray_hit_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    input  logic                                  req_stall,
    input  logic                                  func,
    input  logic [rcb_pkg::INDEX_BITS-1:0]        entry_index,
    input  logic                                  shape_kind,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0] value_0,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0] value_1,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0] value_2,
    input  logic signed [rcb_pkg::VALUE_BITS-1:0] value_3,
    input  logic signed [rcb_pkg::BEAM_BITS-1:0]  value_4,
    input  logic signed [rcb_pkg::BEAM_BITS-1:0]  value_5,
    input  logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    input  logic [rcb_pkg::DIST_BITS-1:0]         distance,
    input  logic                                  cfg_we,
    input  logic [rcb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [rcb_pkg::DIST_BITS-1:0]         cfg_data,
    output int                                    mismatches,
    output int                                    pending
);

    localparam longint SAT_LIM = (64'sd1 <<< 48) - 1;
    localparam int     SLOTS   = rcb_pkg::MAX_OBSTACLES_DEF;

    logic                            obst_shape [SLOTS];
    longint                          obst_param [SLOTS][4];
    logic [rcb_pkg::DIST_BITS-1:0]   range_reg;
    logic [rcb_pkg::COUNT_BITS-1:0]  count_reg;
    logic [rcb_pkg::DIST_BITS-1:0]   distance_q [$];

    function automatic longint clamp_q(longint v);
        if (v > SAT_LIM)
            return SAT_LIM;
        if (v < -SAT_LIM)
            return -SAT_LIM;
        return v;
    endfunction

    function automatic longint unsigned abs_q(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        longint       m;
        p = ({64'd0, abs_q(a)} * {64'd0, abs_q(b)}) >> 16;
        m = (p > SAT_LIM) ? SAT_LIM : longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint fx_div(longint n, longint d);
        logic [127:0] p;
        longint       m;
        p = ({64'd0, abs_q(n)} << 16) / {64'd0, abs_q(d)};
        m = (p > SAT_LIM) ? SAT_LIM : longint'(p[63:0]);
        return ((n < 0) != (d < 0)) ? -m : m;
    endfunction

    function automatic longint root_floor(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int i = 40; i >= 0; i--)
        begin
            c = r | (128'd1 << i);
            if (c * c <= n)
                r = c;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic bit circle_hit(int s, longint ox, longint oy, longint dx,
                                      longint dy, output longint t);
        longint ocx, ocy, b, c, disc, sq, t1, t2;
        ocx  = clamp_q(ox - obst_param[s][0]);
        ocy  = clamp_q(oy - obst_param[s][1]);
        b    = clamp_q(fx_mul(ocx, dx) + fx_mul(ocy, dy));
        c    = clamp_q(clamp_q(fx_mul(ocx, ocx) + fx_mul(ocy, ocy))
                       - fx_mul(obst_param[s][2], obst_param[s][2]));
        disc = clamp_q(fx_mul(b, b) - c);
        t    = 0;
        if (disc < 0)
            return 0;
        sq = root_floor({64'd0, disc} << 16);
        t1 = clamp_q(-b - sq);
        t2 = clamp_q(-b + sq);
        if (t1 >= 0)
        begin
            t = t1;
            return 1;
        end
        if (t2 >= 0)
        begin
            t = t2;
            return 1;
        end
        return 0;
    endfunction

    // one axis of the slab test; a zero component means a parallel slab
    function automatic bit narrow_slab(longint o, longint d, longint lo_edge,
                                       longint hi_edge, inout longint lo,
                                       inout longint hi);
        longint a, b, nv, fv;
        if (d == 0)
            return !(o < lo_edge || o > hi_edge);
        a  = fx_div(clamp_q(lo_edge - o), d);
        b  = fx_div(clamp_q(hi_edge - o), d);
        nv = (a < b) ? a : b;
        fv = (a < b) ? b : a;
        if (nv > lo)
            lo = nv;
        if (fv < hi)
            hi = fv;
        return 1;
    endfunction

    function automatic bit box_hit(int s, longint ox, longint oy, longint dx,
                                   longint dy, output longint t);
        longint lo, hi;
        lo = -SAT_LIM;
        hi = SAT_LIM;
        t  = 0;
        if (!narrow_slab(ox, dx, obst_param[s][0], obst_param[s][2], lo, hi))
            return 0;
        if (!narrow_slab(oy, dy, obst_param[s][1], obst_param[s][3], lo, hi))
            return 0;
        if (!(lo <= hi && hi >= 0))
            return 0;
        t = (lo > 0) ? lo : 0;
        return 1;
    endfunction

    function automatic logic [rcb_pkg::DIST_BITS-1:0] nearest_hit(longint ox,
                                                                  longint oy,
                                                                  longint hc,
                                                                  longint hs,
                                                                  longint bc,
                                                                  longint bs);
        longint dx, dy, best, t;
        int     n;
        bit     hit;
        dx   = clamp_q(fx_mul(bc, hc) - fx_mul(bs, hs));
        dy   = clamp_q(fx_mul(bc, hs) + fx_mul(bs, hc));
        best = longint'(range_reg);
        n    = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
        for (int j = 0; j < n; j++)
        begin
            if (obst_shape[j] == rcb_pkg::SHAPE_BOX)
                hit = box_hit(j, ox, oy, dx, dy, t);
            else
                hit = circle_hit(j, ox, oy, dx, dy, t);
            if (hit && t < best)
                best = t;
        end
        return best[rcb_pkg::DIST_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [rcb_pkg::DIST_BITS-1:0] want;
        if (!rst_n)
        begin
            range_reg  <= rcb_pkg::MAX_RANGE_RST;
            count_reg  <= '0;
            mismatches <= 0;
            pending    <= 0;
            distance_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rcb_pkg::CFG_MAX_RANGE)
                    range_reg <= cfg_data;
                else if (cfg_index == rcb_pkg::CFG_OBSTACLE_COUNT)
                    count_reg <= cfg_data[rcb_pkg::COUNT_BITS-1:0];
            end
            if (req_valid && !req_stall)
            begin
                if (func == rcb_pkg::FUNC_LOAD)
                begin
                    obst_shape[entry_index]    = shape_kind;
                    obst_param[entry_index][0] = value_0;
                    obst_param[entry_index][1] = value_1;
                    obst_param[entry_index][2] = value_2;
                    obst_param[entry_index][3] = value_3;
                end
                else
                    distance_q.push_back(nearest_hit(value_0, value_1, value_2,
                                                     value_3, value_4, value_5));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (distance_q.size() == 0)
                begin
                    $error("distance: unexpected response, actual %0d", distance);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = distance_q.pop_front();
                    if (distance !== want)
                    begin
                        $error("distance: expected %0d, actual %0d", want, distance);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= distance_q.size();
        end
    end

endmodule

// ===== tb/tb_ray_circle_box_nearest_hit_top.sv =====
// ----------------------------------------------------------------------------
// tb_ray_circle_box_nearest_hit_top
// Fills the obstacle table, runs directed casts over circles and boxes, then
// random load/cast traffic in phases with varied range and obstacle count,
// bursty requests and random response stalls. A checker predicts every
// distance; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_ray_circle_box_nearest_hit_top;

    localparam int  WATCHDOG_LIMIT = 200000;
    localparam int  ONE            = 65536;

    logic                                    clk         = 1'b0;
    logic                                    rst_n       = 1'b0;
    logic                                    req_valid   = 1'b0;
    logic                                    req_stall;
    logic                                    func        = rcb_pkg::FUNC_LOAD;
    logic [rcb_pkg::INDEX_BITS-1:0]          entry_index = '0;
    logic                                    shape_kind  = rcb_pkg::SHAPE_CIRCLE;
    logic signed [rcb_pkg::VALUE_BITS-1:0]   value_0     = '0;
    logic signed [rcb_pkg::VALUE_BITS-1:0]   value_1     = '0;
    logic signed [rcb_pkg::VALUE_BITS-1:0]   value_2     = '0;
    logic signed [rcb_pkg::VALUE_BITS-1:0]   value_3     = '0;
    logic signed [rcb_pkg::BEAM_BITS-1:0]    value_4     = '0;
    logic signed [rcb_pkg::BEAM_BITS-1:0]    value_5     = '0;
    logic                                    rsp_valid;
    logic                                    rsp_stall   = 1'b0;
    logic [rcb_pkg::DIST_BITS-1:0]           distance;
    logic                                    cfg_we      = 1'b0;
    logic [rcb_pkg::CFG_INDEX_BITS-1:0]      cfg_index   = '0;
    logic [rcb_pkg::DIST_BITS-1:0]           cfg_data    = '0;

    int mismatches;
    int pending;
    int burst_left = 0;
    int quiet_cycles = 0;
    int stall_pct = 0;
    int stall_tick = 0;

    ray_circle_box_nearest_hit_top DUT (.*);

    ray_hit_checker u_checker (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // response-side stall pattern, its stall percentage re-chosen at random
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 256 == 0)
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic put_request(logic f, int idx, logic shp,
                               int v0, int v1, int v2, int v3, int bc, int bs);
        func        <= f;
        entry_index <= idx[rcb_pkg::INDEX_BITS-1:0];
        shape_kind  <= shp;
        value_0     <= v0;
        value_1     <= v1;
        value_2     <= v2;
        value_3     <= v3;
        value_4     <= bc[rcb_pkg::BEAM_BITS-1:0];
        value_5     <= bs[rcb_pkg::BEAM_BITS-1:0];
        req_valid   <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 1))
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(logic [rcb_pkg::CFG_INDEX_BITS-1:0] idx, int d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d[rcb_pkg::DIST_BITS-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // sender holds off until every distance is back and the block is free
    task automatic drain;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || req_stall)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    function automatic int near_coord();
        return $urandom_range(0, 16 * ONE) - 8 * ONE;
    endfunction

    function automatic int trig_val();
        return $urandom_range(0, 2 * ONE) - ONE;
    endfunction

    task automatic random_load(int slot);
        int v0, v1, v2, v3;
        logic shp;
        shp = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            v0 = $urandom;
            v1 = $urandom;
            v2 = $urandom;
            v3 = $urandom;
        end
        else if (shp == rcb_pkg::SHAPE_CIRCLE)
        begin
            v0 = near_coord();
            v1 = near_coord();
            v2 = $urandom_range(0, 4 * ONE);
            v3 = $urandom;
        end
        else
        begin
            v0 = near_coord();
            v1 = near_coord();
            v2 = v0 + $urandom_range(0, 4 * ONE);
            v3 = v1 + $urandom_range(0, 4 * ONE);
            if ($urandom_range(0, 7) == 0)
                v2 = v0 - $urandom_range(0, 2 * ONE);
        end
        put_request(rcb_pkg::FUNC_LOAD, slot, shp, v0, v1, v2, v3, trig_val(), trig_val());
    endtask

    task automatic random_cast;
        int ox, oy, hc, hs;
        if ($urandom_range(0, 9) == 0)
        begin
            ox = $urandom;
            oy = $urandom;
            hc = $urandom;
            hs = $urandom;
        end
        else
        begin
            ox = near_coord();
            oy = near_coord();
            hc = trig_val();
            hs = trig_val();
            if ($urandom_range(0, 5) == 0)
                hs = 0;
        end
        put_request(rcb_pkg::FUNC_CAST, $urandom, 1'($urandom), ox, oy, hc, hs,
                    trig_val(), trig_val());
    endtask

    initial
    begin
        int range_pick;
        int count_pick;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot gets loaded before any cast can reach it
        for (int s = 0; s < rcb_pkg::MAX_OBSTACLES_DEF; s++)
            random_load(s);

        // directed obstacles: circle ahead, box ahead, swapped box, twin circle
        put_request(rcb_pkg::FUNC_LOAD, 0, rcb_pkg::SHAPE_CIRCLE, 5 * ONE, 0, ONE, 0, 0, 0);
        put_request(rcb_pkg::FUNC_LOAD, 1, rcb_pkg::SHAPE_BOX, 2 * ONE, -ONE, 3 * ONE, ONE,
                    0, 0);
        put_request(rcb_pkg::FUNC_LOAD, 2, rcb_pkg::SHAPE_BOX, 4 * ONE, 2 * ONE, 3 * ONE,
                    -2 * ONE, 0, 0);
        put_request(rcb_pkg::FUNC_LOAD, 3, rcb_pkg::SHAPE_CIRCLE, 5 * ONE, 0, ONE, 0, 0, 0);
        put_request(rcb_pkg::FUNC_LOAD, 63, rcb_pkg::SHAPE_BOX, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        drain();
        write_reg(rcb_pkg::CFG_OBSTACLE_COUNT, 4);
        // along +x (parallel y slab), along -x (miss), diagonal, from inside
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, 0, ONE, 0, ONE, 0);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, 0, ONE, 0, -ONE, 0);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, ONE / 2, 46341, 0, 46341, 46341);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 5 * ONE, 0, 0, ONE, ONE, 0);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, -ONE, ONE);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, 0, 0, 0, ONE, ONE);
        drain();
        write_reg(rcb_pkg::CFG_MAX_RANGE, 0);
        write_reg(rcb_pkg::CFG_OBSTACLE_COUNT, 0);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, 0, ONE, 0, ONE, 0);
        drain();
        write_reg(rcb_pkg::CFG_MAX_RANGE, 32'h7fff_ffff);
        write_reg(rcb_pkg::CFG_OBSTACLE_COUNT, 127);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, 0, ONE, 0, ONE, 0);
        put_request(rcb_pkg::FUNC_CAST, 0, 0, 0, 0, 0, -ONE, ONE, 0);
        drain();
        write_reg(rcb_pkg::CFG_OBSTACLE_COUNT, 64);
        random_cast();
        drain();

        for (int phase = 0; phase < 16; phase++)
        begin
            case ($urandom_range(0, 3))
                0: range_pick = 0;
                1: range_pick = 32'h7fff_ffff;
                2: range_pick = int'(rcb_pkg::MAX_RANGE_RST);
                default: range_pick = $urandom;
            endcase
            count_pick = (phase == 7) ? 64 : $urandom_range(0, 6);
            write_reg(rcb_pkg::CFG_MAX_RANGE, range_pick);
            write_reg(rcb_pkg::CFG_OBSTACLE_COUNT, count_pick);
            for (int k = 0; k < ((phase == 7) ? 6 : 55); k++)
                if ($urandom_range(0, 1))
                    random_load($urandom_range(0, rcb_pkg::MAX_OBSTACLES_DEF - 1));
                else
                    random_cast();
            drain();
        end

        repeat (50)
            @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
